// ===== hdl/pidtw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidtw_pkg
// Shared types, constants and helpers of the PID controller with twiddle
// gain tuning.
// ----------------------------------------------------------------------------
package pidtw_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgKp     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKi     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKd     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStepP  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStepI  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStepD  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTuneEn = 3'd6;

  // reset values, Q8.24, but BestReset is a 17 bit sample magnitude
  localparam logic [31:0] KpReset    = 32'd16777216;
  localparam logic [31:0] KiReset    = 32'd0;
  localparam logic [31:0] KdReset    = 32'd0;
  localparam logic [30:0] StepPReset = 31'd167772;
  localparam logic [30:0] StepIReset = 31'd1678;
  localparam logic [30:0] StepDReset = 31'd1677722;
  localparam logic [16:0] BestReset  = 17'h1FFFF;

  // epsilon 1e-6 in Q8.24: tuning runs when the step sum reaches this
  localparam logic [32:0] StepSumLimit = 33'd17;
  localparam logic [30:0] StepMax      = 31'h7FFF_FFFF;
  // floor(y / 10) = (y * ReciprocalTen) >> 35 for any 32 bit y
  localparam logic [31:0] ReciprocalTen = 32'hCCCC_CCCD;
  localparam int          ReciprocalShift = 35;

  typedef enum logic [2:0] {
    PH_INIT   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  localparam logic [1:0] PhaseCodeInit   = 2'd0;
  localparam logic [1:0] PhaseCodeFirst  = 2'd1;
  localparam logic [1:0] PhaseCodeSecond = 2'd2;

  localparam logic [1:0] GainP = 2'd0;
  localparam logic [1:0] GainI = 2'd1;
  localparam logic [1:0] GainD = 2'd2;

  typedef struct packed {
    logic [2:0][31:0] gains;  // signed Q8.24
    logic [2:0][30:0] steps;  // unsigned Q8.24
    phase_t           phase;
    logic [1:0]       index;
    logic [16:0]      best;
  } tune_state_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] phase_code(input phase_t p);
    logic [1:0] c;
    case (p)
      PH_INIT:   c = PhaseCodeInit;
      PH_FIRST:  c = PhaseCodeFirst;
      PH_SECOND: c = PhaseCodeSecond;
      default:   c = PhaseCodeInit;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pid_controller_with_twiddle_tuning.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_with_twiddle_tuning
// PID control law on Q8.8 cross-track error samples with an optional
// twiddle search that may adjust one Q8.24 gain or its step after each sample.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  ----------------------------------------
//  input    in_valid / in_ready    error_sample
//  output   out_valid / out_ready  control_value, tuning_phase, tuning_index
//  config   cfg_write              cfg_index, cfg_data (write only)
//
//  An accepted item waits in the input register, then passes through the
//  control law and tuner into the result register. One item per cycle is
//  sustained while out_ready stays high; the limit is the combinational path
//  of three gain products plus the twiddle update, which feeds the next item.
//  rst is synchronous and restores the reset gains, steps and tuner state.
//  A stalled result holds in the result register while the input register
//  takes one more item; in_ready drops only when both are full.
//
module pid_controller_with_twiddle_tuning (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [pidtw_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            error_sample,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            control_value,
  output logic [1:0]                    tuning_phase,
  output logic [1:0]                    tuning_index
);

  // input register
  logic               in_reg_valid;
  logic signed [15:0] in_reg_sample;

  // controller state
  logic signed [15:0]     last_error;
  logic signed [31:0]     error_sum;
  logic                   tune_en;
  pidtw_pkg::tune_state_t tst;

  logic                   advance;
  logic signed [31:0]     error_sum_next;
  logic signed [15:0]     control_next;
  pidtw_pkg::tune_state_t tst_next;

  // the held item moves on when the result register is free or emptying
  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  pidtw_law u_law (
    .sample         (in_reg_sample),
    .last_error     (last_error),
    .error_sum      (error_sum),
    .gains          (tst.gains),
    .error_sum_next (error_sum_next),
    .control        (control_next)
  );

  pidtw_tuner u_tuner (
    .sample (in_reg_sample),
    .enable (tune_en),
    .cur    (tst),
    .nxt    (tst_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_sample <= error_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      control_value <= control_next;
      tuning_phase  <= pidtw_pkg::phase_code(tst_next.phase);
      tuning_index  <= tst_next.index;
    end
  end

  // error terms, gains and tuner; config loads the live gain and step copies
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
      tune_en    <= 1'b0;
      tst.gains  <= {pidtw_pkg::KdReset, pidtw_pkg::KiReset, pidtw_pkg::KpReset};
      tst.steps  <= {pidtw_pkg::StepDReset, pidtw_pkg::StepIReset,
                     pidtw_pkg::StepPReset};
      tst.phase  <= pidtw_pkg::PH_INIT;
      tst.index  <= pidtw_pkg::GainP;
      tst.best   <= pidtw_pkg::BestReset;
    end else begin
      if (advance) begin
        last_error <= in_reg_sample;
        error_sum  <= error_sum_next;
        tst        <= tst_next;
      end
      if (cfg_write) begin
        case (cfg_index)
          pidtw_pkg::CfgKp:     tst.gains[pidtw_pkg::GainP] <= cfg_data;
          pidtw_pkg::CfgKi:     tst.gains[pidtw_pkg::GainI] <= cfg_data;
          pidtw_pkg::CfgKd:     tst.gains[pidtw_pkg::GainD] <= cfg_data;
          pidtw_pkg::CfgStepP:  tst.steps[pidtw_pkg::GainP] <= cfg_data[30:0];
          pidtw_pkg::CfgStepI:  tst.steps[pidtw_pkg::GainI] <= cfg_data[30:0];
          pidtw_pkg::CfgStepD:  tst.steps[pidtw_pkg::GainD] <= cfg_data[30:0];
          pidtw_pkg::CfgTuneEn: tune_en <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // ready drops only with both registers full and the output stalled
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_reg_valid && out_valid && !out_ready))
    else $error("in_ready low without a full stalled pipeline");

  // a processed item always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item processed but no result presented");

  // with tuning off, an item leaves gains, steps and tuner state alone
  a_no_tune_when_off: assert property (@(posedge clk) disable iff (rst)
    (advance && !tune_en && !cfg_write) |=> $stable(tst))
    else $error("tuner state changed while tuning disabled");

  // gain index stays within the three gains
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    tst.index != 2'd3)
    else $error("gain index out of range");

endmodule
`default_nettype wire

// ===== hdl/pidtw_law.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidtw_law
// Error terms and control law: difference, saturating integral, three gain
// products, negation, rounding and Q8.8 saturation.
// ----------------------------------------------------------------------------
module pidtw_law (
  input  logic signed [15:0] sample,
  input  logic signed [15:0] last_error,
  input  logic signed [31:0] error_sum,
  input  logic [2:0][31:0]   gains,
  output logic signed [31:0] error_sum_next,
  output logic signed [15:0] control
);

  logic signed [16:0] diff;
  logic signed [32:0] sum_wide;
  logic signed [47:0] prod_p;
  logic signed [63:0] prod_i;
  logic signed [48:0] prod_d;
  logic signed [65:0] acc;
  logic signed [66:0] neg_round;
  logic signed [42:0] ctl_wide;

  assign diff     = 17'(sample) - 17'(last_error);
  assign sum_wide = 33'(error_sum) + 33'(sample);
  assign error_sum_next = $signed(pidtw_pkg::sat32(34'(sum_wide)));

  assign prod_p = $signed(gains[pidtw_pkg::GainP]) * sample;
  assign prod_i = $signed(gains[pidtw_pkg::GainI]) * error_sum_next;
  assign prod_d = $signed(gains[pidtw_pkg::GainD]) * diff;

  assign acc       = 66'(prod_p) + 66'(prod_i) + 66'(prod_d);
  // negate, add half an LSB, floor: ties round toward plus infinity
  assign neg_round = -67'(acc) + 67'sd8388608;
  assign ctl_wide  = 43'(neg_round >>> 24);

  always_comb begin
    if (ctl_wide > 43'sd32767) begin
      control = 16'sh7FFF;
    end else if (ctl_wide < -43'sd32768) begin
      control = -16'sh8000;
    end else begin
      control = ctl_wide[15:0];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pidtw_tuner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidtw_tuner
// One twiddle step: next gains, steps, phase, index and best magnitude.
// ----------------------------------------------------------------------------
module pidtw_tuner (
  input  logic signed [15:0]    sample,
  input  logic                  enable,
  input  pidtw_pkg::tune_state_t cur,
  output pidtw_pkg::tune_state_t nxt
);

  logic [32:0]        step_sum;
  logic               active;
  logic [1:0]         k;
  logic [1:0]         k_next;
  logic [31:0]        g;
  logic [30:0]        s;
  logic signed [16:0] sample_x;
  logic [16:0]        mag;
  logic               better;
  logic [31:0]        gain_plus;
  logic [31:0]        gain_minus2;
  logic [31:0]        div_in;
  logic [63:0]        div_prod;
  logic [28:0]        tenth;
  logic [31:0]        grown;
  logic [30:0]        scaled;

  assign step_sum = 33'(cur.steps[0]) + 33'(cur.steps[1]) + 33'(cur.steps[2]);
  assign active   = enable && (step_sum >= pidtw_pkg::StepSumLimit);

  assign k      = cur.index;
  assign k_next = (k == pidtw_pkg::GainD) ? pidtw_pkg::GainP : k + 2'd1;
  assign g      = cur.gains[k];
  assign s      = cur.steps[k];

  assign sample_x = 17'(sample);
  assign mag      = sample_x[16] ? 17'(-sample_x) : 17'(sample_x);
  assign better   = mag < cur.best;

  // gains are signed: sign-extend before the saturating add
  assign gain_plus   = pidtw_pkg::sat32(34'($signed(g)) + $signed({3'b000, s}));
  assign gain_minus2 = pidtw_pkg::sat32(34'($signed(g)) - $signed({2'b00, s, 1'b0}));

  // step*11/10 rounded = s + (s+5)/10 ; step*9/10 rounded = s - (s+4)/10
  assign div_in   = better ? 32'(s) + 32'd5 : 32'(s) + 32'd4;
  assign div_prod = 64'(div_in) * 64'(pidtw_pkg::ReciprocalTen);
  assign tenth    = div_prod[pidtw_pkg::ReciprocalShift +: 29];
  assign grown    = 32'(s) + 32'(tenth);

  always_comb begin
    if (better) begin
      scaled = (grown > 32'(pidtw_pkg::StepMax)) ? pidtw_pkg::StepMax : grown[30:0];
    end else begin
      scaled = s - 31'(tenth);
    end
  end

  always_comb begin
    nxt = cur;
    if (active) begin
      case (cur.phase)
        pidtw_pkg::PH_INIT: begin
          nxt.gains[k] = gain_plus;
          nxt.phase    = pidtw_pkg::PH_FIRST;
        end
        pidtw_pkg::PH_FIRST: begin
          if (better) begin
            nxt.best     = mag;
            nxt.steps[k] = scaled;
            nxt.index    = k_next;
            nxt.phase    = pidtw_pkg::PH_INIT;
          end else begin
            nxt.gains[k] = gain_minus2;
            nxt.phase    = pidtw_pkg::PH_SECOND;
          end
        end
        pidtw_pkg::PH_SECOND: begin
          if (better) begin
            nxt.best = mag;
          end else begin
            nxt.gains[k] = gain_plus;
          end
          nxt.steps[k] = scaled;
          nxt.index    = k_next;
          nxt.phase    = pidtw_pkg::PH_INIT;
        end
        default: begin
          nxt.phase = pidtw_pkg::PH_INIT;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
